FILE: hdl/mhlc_pkg.sv
// shared types and constants of the multi-hash location cache
`timescale 1ns / 1ps
`default_nettype none
package mhlc_pkg;
	localparam int HASH_COUNT = 4;

	localparam logic [31:0] HASH_MULT [HASH_COUNT] = '{
		32'd1072573589, 32'd3465827623, 32'd2848548977, 32'd748191707
	};

	localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

	localparam logic ACT_SEARCH = 1'b0;
	localparam logic ACT_INSERT = 1'b1;

	typedef logic [1:0] hsel_t;

	typedef struct packed {
		logic [31:0] inode;
		logic [31:0] position;
		logic [31:0] etime;
		logic [63:0] chunk;
		logic [31:0] version;
		logic [7:0]  size;
	} entry_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_DECIDE
	} state_t;
endpackage
`default_nettype wire

FILE: hdl/mhlc_ifs.sv
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface mhlc_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [31:0] inode;
	logic [31:0] position;
	logic [63:0] chunk_id;
	logic [31:0] chunk_version;
	logic [7:0]  location_size;
	logic [31:0] current_time;

	modport source (
		output valid, action, inode, position, chunk_id, chunk_version,
		       location_size, current_time,
		input  ready
	);
	modport sink (
		input  valid, action, inode, position, chunk_id, chunk_version,
		       location_size, current_time,
		output ready
	);
endinterface

interface mhlc_out_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [63:0] found_chunk_id;
	logic [31:0] found_version;
	logic [7:0]  found_size;

	modport source (
		output valid, hit, found_chunk_id, found_version, found_size,
		input  ready
	);
	modport sink (
		input  valid, hit, found_chunk_id, found_version, found_size,
		output ready
	);
endinterface
`default_nettype wire

FILE: hdl/mhlc_hash.sv
// pipelined bucket hash: (inode*m0 + position*m1) mod NUM_BUCKETS, one per cycle
`timescale 1ns / 1ps
`default_nettype none
module mhlc_hash import mhlc_pkg::*; #(
	parameter int NUM_BUCKETS = 1021,
	parameter int BW = 10
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_vld,
	input  wire logic [31:0]   ino,
	input  wire logic [31:0]   pos,
	input  wire hsel_t         hsel,
	output logic               out_vld,
	output hsel_t              out_tag,
	output logic [BW-1:0]      out_bkt
);
	localparam logic [32:0] RECIP = 33'((64'd1 << 32) / NUM_BUCKETS);
	localparam logic [31:0] NB = 32'(NUM_BUCKETS);

	logic [4:0]  vld_q;
	hsel_t       tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;
	logic [31:0] a_s1, pos_s1, mix_s2, mix_s3, q_s3, r_s4;
	logic [BW-1:0] bkt_s5;
	logic [64:0] prod3;
	logic [31:0] qn4;

	assign prod3 = mix_s2 * RECIP;
	assign qn4   = q_s3 * NB;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[3:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		a_s1   <= ino * HASH_MULT[hsel];
		pos_s1 <= pos;
		tag_s1 <= hsel;
		mix_s2 <= a_s1 + pos_s1 * HASH_MULT[~tag_s1];
		tag_s2 <= tag_s1;
		// quotient estimate is low by at most one
		q_s3   <= prod3[63:32];
		mix_s3 <= mix_s2;
		tag_s3 <= tag_s2;
		r_s4   <= mix_s3 - qn4;
		tag_s4 <= tag_s3;
		bkt_s5 <= (r_s4 >= NB) ? BW'(r_s4 - NB) : BW'(r_s4);
		tag_s5 <= tag_s4;
	end

	assign out_vld = vld_q[4];
	assign out_tag = tag_s5;
	assign out_bkt = bkt_s5;
endmodule
`default_nettype wire

FILE: hdl/mhlc_store.sv
// entry memory: one bucket per row, registered row read, per-way or whole-row write
`timescale 1ns / 1ps
`default_nettype none
module mhlc_store import mhlc_pkg::*; #(
	parameter int NUM_BUCKETS = 1021,
	parameter int BUCKET_WAYS = 16,
	parameter int BW = 10,
	parameter int WW = 4
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [BW-1:0] rd_row,
	output entry_t             rd_data [BUCKET_WAYS],
	input  wire logic          wr_en,
	input  wire logic          wr_clear,
	input  wire logic [BW-1:0] wr_row,
	input  wire logic [WW-1:0] wr_way,
	input  wire entry_t        wr_entry
);
	entry_t mem [NUM_BUCKETS][BUCKET_WAYS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (wr_clear) begin
				for (int w = 0; w < BUCKET_WAYS; w++) begin
					mem[wr_row][w] <= '0;
				end
			end else begin
				mem[wr_row][wr_way] <= wr_entry;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_row];
		end
	end
endmodule
`default_nettype wire

FILE: hdl/multi_hash_location_cache.sv
// multi_hash_location_cache: key (inode, position) to chunk id, version, size byte
// Channels: req (sink) carries one search or insert per beat, rsp (source) carries
// exactly one result beat per request, in order. Both use valid/ready.
// After reset the block sweeps the entry memory to zero, one bucket row per cycle,
// every row from 0 to NUM_BUCKETS-1, with req.ready low.
// Each request is handled alone: four bucket hashes enter a five-stage hash pipeline
// back to back, each bucket row is read as its hash leaves the pipe,
// and the 16 ways of a row are compared in the cycle after the read. The decide
// state then writes an insert back, if it has a matching or victim way, and loads the response register.
// A request is answered after its hash pipeline, its four row reads and the decide
// state; a new request is accepted only in the idle state that follows the decide
// state of the last one, so no request is taken while one is in lookup or decide.
// The response sits in an output register, so a stalled receiver holds only that
// beat; the next request is still accepted and processed, and its decide cycle waits
// until the register is free.
`timescale 1ns / 1ps
`default_nettype none
module multi_hash_location_cache import mhlc_pkg::*; #(
	parameter int NUM_BUCKETS = 1021,
	parameter int BUCKET_WAYS = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mhlc_in_if.sink    req,
	mhlc_out_if.source rsp
);
	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int WW = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;
	localparam int P  = 1 << WW;

	state_t state_q, state_d;
	logic [BW-1:0] clr_row_q;
	logic [2:0]    iss_cnt_q;

	logic        act_q;
	logic [31:0] ino_q, pos_q, ver_q, now_q;
	logic [63:0] cid_q;
	logic [7:0]  sz_q;

	logic          hash_ivld, hash_ovld;
	hsel_t         hash_otag;
	logic [BW-1:0] hash_obkt;

	logic          rdv_q, rd_last_q;
	logic [BW-1:0] rd_bkt_q;
	entry_t        rd_row [BUCKET_WAYS];

	logic          hit_q, have_q;
	logic [BW-1:0] hit_bkt_q, vic_bkt_q;
	logic [WW-1:0] hit_way_q, vic_way_q;
	entry_t        hit_ent_q;
	logic [31:0]   best_q;

	logic        rsp_vld_q, rsp_hit_q;
	logic [63:0] rsp_cid_q;
	logic [31:0] rsp_ver_q;
	logic [7:0]  rsp_sz_q;

	logic          req_ready, accept, clearing, out_free, dec_fire, do_write;
	logic          row_hit;
	logic [WW-1:0] row_hit_way;
	logic [31:0]   nt [2*P];
	logic [WW-1:0] ni [2*P];

	logic          wr_en;
	logic [BW-1:0] wr_row;
	logic [WW-1:0] wr_way;
	entry_t        wr_entry;

	assign accept   = req.valid && req_ready;
	assign out_free = !rsp_vld_q || rsp.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_row_q == BW'(NUM_BUCKETS - 1)) state_d = ST_IDLE;
			ST_IDLE:   if (req.valid) state_d = ST_LOOKUP;
			ST_LOOKUP: if (rdv_q && rd_last_q) state_d = ST_DECIDE;
			ST_DECIDE: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	// state outputs
	always_comb begin
		req_ready = 1'b0;
		clearing  = 1'b0;
		hash_ivld = 1'b0;
		dec_fire  = 1'b0;
		case (state_q)
			ST_CLEAR:  clearing = 1'b1;
			ST_IDLE:   req_ready = 1'b1;
			ST_LOOKUP: hash_ivld = (iss_cnt_q < 3'(HASH_COUNT));
			ST_DECIDE: dec_fire = out_free;
			default:   clearing = 1'b0;
		endcase
	end

	assign do_write = dec_fire && (act_q == ACT_INSERT) && (hit_q || have_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_row_q <= '0;
			iss_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (clearing) clr_row_q <= clr_row_q + 1'b1;
			if (accept) begin
				iss_cnt_q <= '0;
			end else if (hash_ivld) begin
				iss_cnt_q <= iss_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= req.action;
			ino_q <= req.inode;
			pos_q <= req.position;
			cid_q <= req.chunk_id;
			ver_q <= req.chunk_version;
			sz_q  <= req.location_size;
			now_q <= req.current_time;
		end
	end

	mhlc_hash #(.NUM_BUCKETS(NUM_BUCKETS), .BW(BW)) u_hash (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (hash_ivld),
		.ino     (ino_q),
		.pos     (pos_q),
		.hsel    (iss_cnt_q[1:0]),
		.out_vld (hash_ovld),
		.out_tag (hash_otag),
		.out_bkt (hash_obkt)
	);

	assign wr_en    = clearing || do_write;
	assign wr_row   = clearing ? clr_row_q : (hit_q ? hit_bkt_q : vic_bkt_q);
	assign wr_way   = hit_q ? hit_way_q : vic_way_q;
	assign wr_entry = '{inode: ino_q, position: pos_q, etime: now_q, chunk: cid_q,
	                    version: ver_q, size: sz_q};

	mhlc_store #(
		.NUM_BUCKETS(NUM_BUCKETS), .BUCKET_WAYS(BUCKET_WAYS), .BW(BW), .WW(WW)
	) u_store (
		.clk      (clk),
		.rd_en    (hash_ovld),
		.rd_row   (hash_obkt),
		.rd_data  (rd_row),
		.wr_en    (wr_en),
		.wr_clear (clearing),
		.wr_row   (wr_row),
		.wr_way   (wr_way),
		.wr_entry (wr_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdv_q     <= 1'b0;
			rd_last_q <= 1'b0;
		end else begin
			rdv_q     <= hash_ovld;
			rd_last_q <= (hash_otag == hsel_t'(HASH_COUNT - 1));
		end
	end

	always_ff @(posedge clk) begin
		rd_bkt_q <= hash_obkt;
	end

	// first matching way, and oldest way by a tie-to-lower tree
	always_comb begin
		row_hit     = 1'b0;
		row_hit_way = '0;
		for (int w = BUCKET_WAYS - 1; w >= 0; w--) begin
			if (rd_row[w].inode == ino_q && rd_row[w].position == pos_q) begin
				row_hit     = 1'b1;
				row_hit_way = WW'(w);
			end
		end
		nt[0] = TIME_MAX;
		ni[0] = '0;
		for (int i = 0; i < P; i++) begin
			nt[P+i] = (i < BUCKET_WAYS) ? rd_row[i % BUCKET_WAYS].etime : TIME_MAX;
			ni[P+i] = WW'(i);
		end
		for (int n = P - 1; n >= 1; n--) begin
			if (nt[2*n+1] < nt[2*n]) begin
				nt[n] = nt[2*n+1];
				ni[n] = ni[2*n+1];
			end else begin
				nt[n] = nt[2*n];
				ni[n] = ni[2*n];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			have_q <= 1'b0;
			best_q <= TIME_MAX;
		end else if (accept) begin
			hit_q  <= 1'b0;
			have_q <= 1'b0;
			best_q <= TIME_MAX;
		end else if (rdv_q) begin
			if (!hit_q && row_hit) hit_q <= 1'b1;
			if (nt[1] < best_q) begin
				best_q <= nt[1];
				have_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdv_q) begin
			if (!hit_q && row_hit) begin
				hit_bkt_q <= rd_bkt_q;
				hit_way_q <= row_hit_way;
				hit_ent_q <= rd_row[row_hit_way];
			end
			if (nt[1] < best_q) begin
				vic_bkt_q <= rd_bkt_q;
				vic_way_q <= ni[1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (dec_fire) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dec_fire) begin
			rsp_hit_q <= hit_q;
			if (act_q == ACT_SEARCH && hit_q) begin
				rsp_cid_q <= hit_ent_q.chunk;
				rsp_ver_q <= hit_ent_q.version;
				rsp_sz_q  <= hit_ent_q.size;
			end else begin
				rsp_cid_q <= '0;
				rsp_ver_q <= '0;
				rsp_sz_q  <= '0;
			end
		end
	end

	assign req.ready          = req_ready;
	assign rsp.valid          = rsp_vld_q;
	assign rsp.hit            = rsp_hit_q;
	assign rsp.found_chunk_id = rsp_cid_q;
	assign rsp.found_version  = rsp_ver_q;
	assign rsp.found_size     = rsp_sz_q;

	a_hash_in_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		hash_ovld |-> state_q == ST_LOOKUP)
		else $error("hash result outside lookup");

	a_write_when: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_CLEAR || state_q == ST_DECIDE))
		else $error("memory write outside clear or decide");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		rdv_q |-> (32'(rd_bkt_q) < 32'(NUM_BUCKETS)))
		else $error("bucket index out of range");

	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		iss_cnt_q <= 3'(HASH_COUNT))
		else $error("too many hashes issued");
endmodule
`default_nettype wire

FILE: bench/multi_hash_location_cache_checker.sv
// checker: predicts each cache result and compares it with the response channel
`timescale 1ns / 1ps
`default_nettype none
module multi_hash_location_cache_checker import mhlc_pkg::*; #(
	parameter int NUM_BUCKETS = 1021,
	parameter int BUCKET_WAYS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mhlc_in_if.sink   req_mon,
	mhlc_out_if.sink  rsp_mon,
	output int        outstanding,
	output int        fail_count
);
	localparam int ENTRIES = NUM_BUCKETS * BUCKET_WAYS;

	typedef struct {
		logic        hit;
		logic [63:0] chunk;
		logic [31:0] version;
		logic [7:0]  size;
	} lookup_t;

	logic [31:0] key_inode [ENTRIES];
	logic [31:0] key_pos   [ENTRIES];
	logic [31:0] stamp     [ENTRIES];
	logic [63:0] chunk_mem [ENTRIES];
	logic [31:0] ver_mem   [ENTRIES];
	logic [7:0]  size_mem  [ENTRIES];

	lookup_t pending_lookups [$];

	function automatic int row_base(logic [31:0] ino, logic [31:0] pos, int h);
		logic [31:0] mix;
		mix = ino * HASH_MULT[h] + pos * HASH_MULT[HASH_COUNT - 1 - h];
		return int'(mix % NUM_BUCKETS) * BUCKET_WAYS;
	endfunction

	// applies one request to the shadow store and returns what the block must answer
	function automatic lookup_t cache_access(logic act, logic [31:0] ino, logic [31:0] pos,
			logic [63:0] cid, logic [31:0] ver, logic [7:0] sz, logic [31:0] now);
		lookup_t r;
		int slot;
		int e;
		logic found;
		logic have;
		logic [31:0] oldest;
		r = '{1'b0, 64'd0, 32'd0, 8'd0};
		found = 1'b0;
		slot = 0;
		for (int h = 0; h < HASH_COUNT && !found; h++)
			for (int w = 0; w < BUCKET_WAYS && !found; w++) begin
				e = row_base(ino, pos, h) + w;
				if (key_inode[e] == ino && key_pos[e] == pos) begin
					found = 1'b1;
					slot = e;
				end
			end
		r.hit = found;
		if (act == ACT_SEARCH) begin
			if (found) begin
				r.chunk = chunk_mem[slot];
				r.version = ver_mem[slot];
				r.size = size_mem[slot];
			end
			return r;
		end
		if (!found) begin
			oldest = TIME_MAX;
			have = 1'b0;
			for (int h = 0; h < HASH_COUNT; h++)
				for (int w = 0; w < BUCKET_WAYS; w++) begin
					e = row_base(ino, pos, h) + w;
					if (stamp[e] < oldest) begin
						oldest = stamp[e];
						slot = e;
						have = 1'b1;
					end
				end
			// every scanned entry at the maximal time: nothing is written
			if (!have)
				return r;
			key_inode[slot] = ino;
			key_pos[slot] = pos;
		end
		chunk_mem[slot] = cid;
		ver_mem[slot] = ver;
		size_mem[slot] = sz;
		stamp[slot] = now;
		return r;
	endfunction

	initial begin
		fail_count = 0;
		outstanding = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			key_inode[i] = '0;
			key_pos[i] = '0;
			stamp[i] = '0;
			chunk_mem[i] = '0;
			ver_mem[i] = '0;
			size_mem[i] = '0;
		end
	end

	always @(posedge clk) begin
		lookup_t want;
		if (arst_n) begin
			if (rsp_mon.valid && rsp_mon.ready) begin
				if (pending_lookups.size() == 0) begin
					$error("response beat with no request waiting");
					fail_count++;
				end else begin
					want = pending_lookups.pop_front();
					if (rsp_mon.hit !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, rsp_mon.hit);
						fail_count++;
					end
					if (rsp_mon.found_chunk_id !== want.chunk) begin
						$error("found_chunk_id: expected %h, got %h", want.chunk,
							rsp_mon.found_chunk_id);
						fail_count++;
					end
					if (rsp_mon.found_version !== want.version) begin
						$error("found_version: expected %h, got %h", want.version,
							rsp_mon.found_version);
						fail_count++;
					end
					if (rsp_mon.found_size !== want.size) begin
						$error("found_size: expected %h, got %h", want.size,
							rsp_mon.found_size);
						fail_count++;
					end
				end
			end
			if (req_mon.valid && req_mon.ready)
				pending_lookups.push_back(cache_access(req_mon.action, req_mon.inode,
					req_mon.position, req_mon.chunk_id, req_mon.chunk_version,
					req_mon.location_size, req_mon.current_time));
			outstanding = pending_lookups.size();
		end
	end
endmodule
`default_nettype wire

FILE: bench/multi_hash_location_cache_test.sv
// testbench top: clock, reset, request stimulus, response back-pressure and verdict
`timescale 1ns / 1ps
`default_nettype none
module multi_hash_location_cache_test import mhlc_pkg::*;;
	localparam int NUM_BUCKETS = 1021;
	localparam int BUCKET_WAYS = 16;
	localparam int RANDOM_ITEMS = 1150;

	logic clk;
	logic arst_n;
	int   outstanding;
	int   fail_count;

	mhlc_in_if  req ();
	mhlc_out_if rsp ();

	multi_hash_location_cache #(
		.NUM_BUCKETS(NUM_BUCKETS),
		.BUCKET_WAYS(BUCKET_WAYS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	multi_hash_location_cache_checker #(
		.NUM_BUCKETS(NUM_BUCKETS),
		.BUCKET_WAYS(BUCKET_WAYS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_mon(req.sink),
		.rsp_mon(rsp.sink),
		.outstanding(outstanding),
		.fail_count(fail_count)
	);

	logic [31:0] pool_inode [32];
	logic [31:0] pool_pos   [32];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("multi_hash_location_cache: mismatch");
		$finish;
	end

	function automatic int bucket_of(logic [31:0] ino, logic [31:0] pos, int h);
		logic [31:0] mix;
		mix = ino * HASH_MULT[h] + pos * HASH_MULT[HASH_COUNT - 1 - h];
		return int'(mix % NUM_BUCKETS);
	endfunction

	function automatic int short_or_long_gap();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	function automatic logic [31:0] pick_time();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return TIME_MAX;
			2: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	// one beat on the request channel; back-to-back beats keep valid high
	task automatic send(logic act, logic [31:0] ino, logic [31:0] pos, logic [63:0] cid,
			logic [31:0] ver, logic [7:0] sz, logic [31:0] now, int gap);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.action <= act;
		req.inode <= ino;
		req.position <= pos;
		req.chunk_id <= cid;
		req.chunk_version <= ver;
		req.location_size <= sz;
		req.current_time <= now;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic send_random(logic [31:0] ino, logic [31:0] pos);
		send(1'($urandom_range(0, 1)), ino, pos, {$urandom, $urandom}, $urandom,
			8'($urandom_range(0, 255)), pick_time(), short_or_long_gap());
	endtask

	// fills every bucket of one key with entries at the maximal time
	task automatic saturate_buckets();
		logic [31:0] t_ino;
		logic [31:0] t_pos;
		int tb [HASH_COUNT];
		int filled [HASH_COUNT];
		int b;
		int done;
		logic [31:0] cand;
		logic ok;
		t_ino = 32'd7;
		t_pos = 32'd0;
		do begin
			t_pos++;
			ok = 1'b1;
			for (int h = 0; h < HASH_COUNT; h++) begin
				tb[h] = bucket_of(t_ino, t_pos, h);
				if (tb[h] == 0)
					ok = 1'b0;
				for (int k = 0; k < h; k++)
					if (tb[k] == tb[h])
						ok = 1'b0;
			end
		end while (!ok);
		for (int h = 0; h < HASH_COUNT; h++)
			filled[h] = 0;
		done = 0;
		cand = 32'd0;
		// a fresh key lands in the first cleared way of its first bucket
		while (done < HASH_COUNT * BUCKET_WAYS) begin
			cand++;
			b = bucket_of(32'd1, cand, 0);
			for (int h = 0; h < HASH_COUNT; h++)
				if (b == tb[h] && filled[h] < BUCKET_WAYS) begin
					filled[h]++;
					done++;
					send(ACT_INSERT, 32'd1, cand, {$urandom, $urandom}, $urandom,
						8'($urandom_range(0, 255)), TIME_MAX, $urandom_range(0, 1));
				end
		end
		send(ACT_INSERT, t_ino, t_pos, '1, '1, 8'hFF, 32'd5, 0);
		send(ACT_SEARCH, t_ino, t_pos, '0, '0, 8'h00, 32'd0, 0);
		send(ACT_SEARCH, 32'd1, cand, '0, '0, 8'h00, 32'd0, 1);
	endtask

	initial begin
		int k;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.action = ACT_SEARCH;
		req.inode = '0;
		req.position = '0;
		req.chunk_id = '0;
		req.chunk_version = '0;
		req.location_size = '0;
		req.current_time = '0;
		for (int i = 0; i < 32; i++) begin
			pool_inode[i] = (i < 8) ? $urandom_range(0, 3) : $urandom;
			pool_pos[i] = (i < 8) ? $urandom_range(0, 3) : $urandom;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		saturate_buckets();
		// cleared entries hold key (0,0)
		send(ACT_SEARCH, '0, '0, '0, '0, '0, '0, 0);
		send(ACT_SEARCH, '1, '1, '0, '0, '0, '0, 0);
		send(ACT_INSERT, '0, '0, '1, '1, 8'hFF, '1, 0);
		send(ACT_SEARCH, '0, '0, '0, '0, '0, '0, 2);
		send(ACT_INSERT, '1, '1, '1, '1, 8'hFF, '0, 0);
		send(ACT_SEARCH, '1, '1, '0, '0, '0, '0, 0);
		send(ACT_INSERT, '1, '1, 64'h0123_4567_89AB_CDEF, 32'h5555_AAAA, 8'h5A, 32'd3, 1);
		send(ACT_SEARCH, '1, '1, '1, '1, 8'hFF, '1, 0);
		send(ACT_INSERT, 32'h8000_0000, 32'h0000_0001, '0, '0, '0, 32'd9, 0);
		send(ACT_SEARCH, 32'h8000_0000, 32'h0000_0001, '0, '0, '0, '0, 0);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2) begin
				req.valid <= 1'b0;
				// let the checker log the last accepted beat before draining
				@(posedge clk);
				while (outstanding != 0) @(posedge clk);
			end
			k = $urandom_range(0, 31);
			case ($urandom_range(0, 9))
				0: send_random($urandom, $urandom);
				1: send_random('0, '0);
				default: send_random(pool_inode[k], pool_pos[k]);
			endcase
		end
		req.valid <= 1'b0;
		@(posedge clk);

		k = 0;
		while (outstanding != 0 && k < 100000) begin
			@(posedge clk);
			k++;
		end
		repeat (30) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("multi_hash_location_cache: match");
		else
			$display("multi_hash_location_cache: mismatch");
		$finish;
	end

	// response back-pressure: runs of ready and stalls, mostly short
	initial begin
		int run;
		rsp.ready = 1'b0;
		forever begin
			run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
			rsp.ready <= 1'b1;
			repeat (run) @(posedge clk);
			rsp.ready <= 1'b0;
			repeat (short_or_long_gap() + 1) @(posedge clk);
		end
	end
endmodule
`default_nettype wire

FILE: multi_hash_location_cache.f
hdl/mhlc_pkg.sv
hdl/mhlc_ifs.sv
hdl/mhlc_hash.sv
hdl/mhlc_store.sv
hdl/multi_hash_location_cache.sv
bench/multi_hash_location_cache_checker.sv
bench/multi_hash_location_cache_test.sv
